### hw/rtl/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg: shared types for the LIFO stack with search
// Beat layouts of both channels, result status codes and operation codes.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned MODE_W  = 4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH     = 4'd0,
    MODE_POP      = 4'd1,
    MODE_PEEK     = 4'd2,
    MODE_SIZE     = 4'd3,
    MODE_IS_EMPTY = 4'd4,
    MODE_SEARCH   = 4'd5,
    MODE_UPDATE   = 4'd6,
    MODE_REVERSE  = 4'd7,
    MODE_CLEAR    = 4'd8,
    MODE_DISPLAY  = 4'd9
  } mode_e;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] new_value;
  } lss_in_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] data;
    logic [COUNT_W-1:0]       count;
    logic                     last;
  } lss_out_t;

endpackage

### hw/rtl/lifo_stack_with_search.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_search: bounded LIFO stack of signed words with search
// Push, pop, peek, size, is-empty, search, update, reverse, clear and
// display on a stack of DEPTH entries held in one synchronous RAM.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake             | Beat
//  --------+-----------+-----------------------+---------------------------
//  in      | input     | in_valid_i/in_ready_o | lss_in_t  (mode, values)
//  out     | output    | out_valid_o/out_ready_i| lss_out_t (status, data,
//          |           |                       |  count, last)
//
// Push, size, is-empty, clear and unused modes go from accept through the
// response state to the result register; pop and peek also pass through a
// read state that takes the registered RAM read data. Search and update
// issue one RAM read per cycle from the top until a match or the bottom.
// Reverse swaps each pair with two reads and two writes on the single RAM
// port pair; display sends each entry before it reads the next. The RAM
// contents are not cleared at reset; only the entry count is, so the block
// is ready right after reset. An item is taken only in the idle state, even
// while a result still sits in the output register; a stalled output holds
// the sequencer in its response state until the beat is taken.
//
module lifo_stack_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lss_pkg::lss_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lss_pkg::lss_out_t out_data_o
);
  import lss_pkg::*;

  // Address width of the store and width of the entry count, which must
  // also hold DEPTH itself.
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);
  localparam logic [AW:0]   TWO_GAP  = (AW + 1)'(2);

  // One-hot sequencer states.
  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_READ    = 10'b00_0000_0010,
    S_SCAN    = 10'b00_0000_0100,
    S_REV_A   = 10'b00_0000_1000,
    S_REV_B   = 10'b00_0001_0000,
    S_REV_C   = 10'b00_0010_0000,
    S_REV_D   = 10'b00_0100_0000,
    S_DISP_RD = 10'b00_1000_0000,
    S_DISP_WT = 10'b01_0000_0000,
    S_RESP    = 10'b10_0000_0000
  } state_e;

  state_e                   state_q, state_d;
  logic [CW-1:0]            count_q, count_d;
  logic                     out_valid_q, out_valid_d;
  lss_out_t                 out_q, out_d;
  logic                     pend_q, pend_d;

  // Working registers of the current item.
  logic [CW-1:0]            rem_q, rem_d;
  logic [AW-1:0]            pa_q, pa_d;
  logic [AW-1:0]            lo_q, lo_d;
  logic [AW-1:0]            hi_q, hi_d;
  logic [DATA_W-1:0]        key_q, key_d;
  logic [DATA_W-1:0]        nval_q, nval_d;
  logic [DATA_W-1:0]        tmp_q, tmp_d;
  logic                     upd_q, upd_d;
  status_e                  res_status_q, res_status_d;
  logic [DATA_W-1:0]        res_data_q, res_data_d;
  logic                     res_last_q, res_last_d;

  // RAM port signals.
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;

  logic [CW-1:0]            count_m1;
  logic [CW-1:0]            rem_m1;
  logic [CW+COUNT_W-1:0]    count_ext;
  logic                     out_free;

  lss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign count_m1  = count_q - ONE_CNT;
  assign rem_m1    = rem_q - ONE_CNT;
  // The reported count is the entry count masked to the field width.
  assign count_ext = {{COUNT_W{1'b0}}, count_q};
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    pend_d       = pend_q;
    rem_d        = rem_q;
    pa_d         = pa_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    key_d        = key_q;
    nval_d       = nval_q;
    tmp_d        = tmp_q;
    upd_d        = upd_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_last_d   = res_last_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          // Every result starts as ok, no data, final beat of the item.
          key_d        = in_data_i.value;
          nval_d       = in_data_i.new_value;
          res_status_d = ST_OK;
          res_data_d   = '0;
          res_last_d   = 1'b1;
          state_d      = S_RESP;
          case (in_data_i.mode)
            MODE_PUSH: begin
              if (count_q == FULL_CNT) begin
                res_status_d = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = count_q[AW-1:0];
                ram_wdata  = in_data_i.value;
                count_d    = count_q + ONE_CNT;
                res_data_d = in_data_i.value;
              end
            end
            MODE_POP, MODE_PEEK: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = count_m1[AW-1:0];
                if (in_data_i.mode == MODE_POP) begin
                  count_d = count_m1;
                end
                state_d = S_READ;
              end
            end
            MODE_SIZE: begin
            end
            MODE_IS_EMPTY: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end
            end
            MODE_SEARCH, MODE_UPDATE: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                rem_d   = count_q;
                pend_d  = 1'b0;
                upd_d   = (in_data_i.mode == MODE_UPDATE);
                state_d = S_SCAN;
              end
            end
            MODE_REVERSE: begin
              if (count_q > ONE_CNT) begin
                lo_d    = '0;
                hi_d    = count_m1[AW-1:0];
                state_d = S_REV_A;
              end
            end
            MODE_CLEAR: begin
              count_d = '0;
            end
            MODE_DISPLAY: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                rem_d   = count_q;
                state_d = S_DISP_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_READ: begin
        res_data_d = ram_rdata;
        state_d    = S_RESP;
      end

      // Walk from the top, one read issued per cycle; the compare looks at
      // the word read in the previous cycle.
      S_SCAN: begin
        if (pend_q && (ram_rdata == key_q)) begin
          if (upd_q) begin
            ram_we     = 1'b1;
            ram_waddr  = pa_q;
            ram_wdata  = nval_q;
            res_data_d = nval_q;
          end else begin
            res_data_d = key_q;
          end
          state_d = S_RESP;
        end else if (rem_q == '0) begin
          res_status_d = ST_NOTFOUND;
          state_d      = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = rem_m1[AW-1:0];
          pa_d      = rem_m1[AW-1:0];
          rem_d     = rem_m1;
          pend_d    = 1'b1;
        end
      end

      // Swap one pair: read low, read high, write low, write high.
      S_REV_A: begin
        ram_re    = 1'b1;
        ram_raddr = lo_q;
        state_d   = S_REV_B;
      end
      S_REV_B: begin
        ram_re    = 1'b1;
        ram_raddr = hi_q;
        tmp_d     = ram_rdata;
        state_d   = S_REV_C;
      end
      S_REV_C: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q;
        ram_wdata = ram_rdata;
        state_d   = S_REV_D;
      end
      S_REV_D: begin
        ram_we    = 1'b1;
        ram_waddr = hi_q;
        ram_wdata = tmp_q;
        lo_d      = lo_q + AW'(1);
        hi_d      = hi_q - AW'(1);
        if (({1'b0, hi_q} - {1'b0, lo_q}) > TWO_GAP) begin
          state_d = S_REV_A;
        end else begin
          state_d = S_RESP;
        end
      end

      S_DISP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = rem_m1[AW-1:0];
        rem_d     = rem_m1;
        state_d   = S_DISP_WT;
      end
      S_DISP_WT: begin
        res_status_d = ST_OK;
        res_data_d   = ram_rdata;
        res_last_d   = (rem_q == '0);
        state_d      = S_RESP;
      end

      // The entry count is final here, so it goes straight into the beat.
      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_d.status = res_status_q;
          out_d.data   = res_data_q;
          out_d.count  = count_ext[COUNT_W-1:0];
          out_d.last   = res_last_q;
          state_d      = res_last_q ? S_IDLE : S_DISP_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q        <= out_d;
    rem_q        <= rem_d;
    pa_q         <= pa_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    key_q        <= key_d;
    nval_q       <= nval_d;
    tmp_q        <= tmp_d;
    upd_q        <= upd_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_last_q   <= res_last_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hw/rtl/lss_ram.sv
// ----------------------------------------------------------------------------
// lss_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/lss_checker.sv
// ----------------------------------------------------------------------------
// lss_checker: port-level checks for the LIFO stack with search
// Watches the top-level ports and flags inconsistent result beats.
// ----------------------------------------------------------------------------
module lss_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input lss_pkg::lss_out_t out_data_o
);
  import lss_pkg::*;

  localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(DEPTH % (2 ** COUNT_W));

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in progress");

  // A full status is only reported on a full stack.
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_FULL) |-> out_data_o.count == FULL_CNT)
    else $error("full status with a stack that is not full");

  // An empty status is only reported on an empty stack, with no data.
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_EMPTY) |->
      (out_data_o.count == '0) && (out_data_o.data == '0))
    else $error("empty status with entries on the stack");

  // Only display produces beats that are not final, and those are all ok.
  a_mid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.status == ST_OK)
    else $error("non-final result beat without ok status");

endmodule

bind lifo_stack_with_search lss_checker #(.DEPTH(DEPTH)) u_lss_checker (.*);

### tb/sv/lifo_stack_with_search_checker.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_search_checker: result checker for the LIFO stack
// Watches both channels of the stack, keeps a shadow copy of the stored
// entries, and compares every result beat field by field in order.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  lss_pkg::lss_in_t  in_beat_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  lss_pkg::lss_out_t out_beat_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lss_pkg::*;

  localparam int PRINT_CAP = 200;

  // Results owed by the stack, oldest first.
  lss_out_t                  stack_results_q[$];
  // Shadow of the stack contents; slot 0 is the bottom.
  logic signed [DATA_W-1:0]  shadow_mem [DEPTH];
  int unsigned               shadow_fill;
  int                        fail_count = 0;

  assign fail_count_o = fail_count;

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP) begin
      $display("%0t: stack mismatch: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  // Queues one result; count always reflects the state after the operation.
  task automatic owe_result(input status_e st, input logic signed [DATA_W-1:0] d,
                            input logic lst);
    lss_out_t r;
    r.status = st;
    r.data   = d;
    r.count  = COUNT_W'(shadow_fill);
    r.last   = lst;
    stack_results_q.push_back(r);
  endtask

  task automatic apply_stack_op(input lss_in_t op);
    int                       hit;
    int                       lo;
    int                       hi;
    logic signed [DATA_W-1:0] tmp;
    hit = -1;
    // Search and update act on the topmost match only.
    for (int i = int'(shadow_fill) - 1; i >= 0; i--) begin
      if (hit < 0 && shadow_mem[i] == op.value) hit = i;
    end
    case (op.mode)
      MODE_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          owe_result(ST_FULL, '0, 1'b1);
        end else begin
          shadow_mem[shadow_fill] = op.value;
          shadow_fill++;
          owe_result(ST_OK, op.value, 1'b1);
        end
      end
      MODE_POP: begin
        if (shadow_fill == 0) begin
          owe_result(ST_EMPTY, '0, 1'b1);
        end else begin
          shadow_fill--;
          owe_result(ST_OK, shadow_mem[shadow_fill], 1'b1);
        end
      end
      MODE_PEEK: begin
        if (shadow_fill == 0) owe_result(ST_EMPTY, '0, 1'b1);
        else owe_result(ST_OK, shadow_mem[shadow_fill-1], 1'b1);
      end
      MODE_SIZE:     owe_result(ST_OK, '0, 1'b1);
      MODE_IS_EMPTY: owe_result(status_e'((shadow_fill == 0) ? ST_EMPTY : ST_OK),
                                '0, 1'b1);
      MODE_SEARCH: begin
        if (shadow_fill == 0) owe_result(ST_EMPTY, '0, 1'b1);
        else if (hit < 0) owe_result(ST_NOTFOUND, '0, 1'b1);
        else owe_result(ST_OK, op.value, 1'b1);
      end
      MODE_UPDATE: begin
        if (shadow_fill == 0) begin
          owe_result(ST_EMPTY, '0, 1'b1);
        end else if (hit < 0) begin
          owe_result(ST_NOTFOUND, '0, 1'b1);
        end else begin
          shadow_mem[hit] = op.new_value;
          owe_result(ST_OK, op.new_value, 1'b1);
        end
      end
      MODE_REVERSE: begin
        lo = 0;
        hi = int'(shadow_fill) - 1;
        while (lo < hi) begin
          tmp            = shadow_mem[lo];
          shadow_mem[lo] = shadow_mem[hi];
          shadow_mem[hi] = tmp;
          lo++;
          hi--;
        end
        owe_result(ST_OK, '0, 1'b1);
      end
      MODE_CLEAR: begin
        shadow_fill = 0;
        owe_result(ST_OK, '0, 1'b1);
      end
      MODE_DISPLAY: begin
        if (shadow_fill == 0) begin
          owe_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = int'(shadow_fill) - 1; i >= 0; i--) begin
            owe_result(ST_OK, shadow_mem[i], i == 0);
          end
        end
      end
      // Unused codes leave the stack alone.
      default: owe_result(ST_OK, '0, 1'b1);
    endcase
  endtask

  task automatic check_result(input lss_out_t got);
    lss_out_t want;
    if (stack_results_q.size() == 0) begin
      report_mismatch($sformatf("result beat with none owed (status %0d data %0d)",
                                got.status, got.data));
    end else begin
      want = stack_results_q.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.data !== want.data)
        report_mismatch($sformatf("data %0d, want %0d", got.data, want.data));
      if (got.count !== want.count)
        report_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_results_q.delete();
      shadow_fill = 0;
      pending_o <= 0;
    end else begin
      // A result can never come out in the cycle its operation went in,
      // so the order of these two makes no difference.
      if (out_valid_i && out_ready_i) check_result(out_beat_i);
      if (in_valid_i && in_ready_i) apply_stack_op(in_beat_i);
      pending_o <= stack_results_q.size();
    end
  end

endmodule

### tb/sv/lifo_stack_with_search_test.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_search_test: testbench top for the LIFO stack with search
// Drives directed and random stack operations with random idle gaps on the
// input and random stalls on the output; the checker grades every beat.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lss_pkg::*;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int          CLK_PERIOD  = 10;
  localparam int          RESET_CYCLES = 7;
  localparam int          RANDOM_OPS  = 340;
  // The tail covers the slowest operation, a full display or reverse.
  localparam int          TAIL_CYCLES = 80;
  // Worst legal pace: 16 display beats each stalled by the longest gap, plus
  // a long input gap, for every operation; then several times that.
  localparam longint      CYCLE_LIMIT = 1_500_000;

  localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 4'd10;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 4'd15;

  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  lss_in_t  in_beat   = '0;
  logic     in_ready;
  logic     out_valid;
  logic     out_ready = 1'b0;
  lss_out_t out_beat;
  int       fail_count;
  int       pending;

  // Idle and stall odds in percent; changed from one phase to the next.
  int       idle_pct   = 0;
  int       stall_pct  = 0;
  int       stall_left = 0;
  int       sent_ops   = 0;
  longint   cycle_count = 0;

  // Values that searches and updates pick from, so that many of them hit.
  logic signed [DATA_W-1:0] value_pool [8];

  lifo_stack_with_search #(
    .DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_beat),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_beat)
  );

  lifo_stack_with_search_checker #(
    .DEPTH(STACK_DEPTH)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_beat_i   (in_beat),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_beat_i  (out_beat),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** lifo_stack_with_search: FAILED **");
      $finish;
    end
  end

  // Most gaps are short; now and then one is long enough to let a
  // display or a search run far ahead of the other side.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Output stalls. Ready is moved only at the falling edge, so the stack
  // sees a stable value at every rising edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Presents one operation and holds it until the stack takes the beat.
  // Valid is left high after acceptance so that back-to-back beats need no
  // bubble; the next call or the drain pause decides what happens to it.
  task automatic send_op(input logic [MODE_W-1:0] m, input logic signed [DATA_W-1:0] v,
                         input logic signed [DATA_W-1:0] nv);
    int      gap;
    lss_in_t beat;
    gap = ($urandom_range(0, 99) < idle_pct) ? pick_gap() : 0;
    beat.mode      = m;
    beat.value     = v;
    beat.new_value = nv;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_beat  <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent_ops++;
  endtask

  // Holds off new operations until every owed result beat has come back.
  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic refresh_pool();
    for (int k = 0; k < 8; k++) begin
      case ($urandom_range(0, 9))
        0:       value_pool[k] = WORD_MIN;
        1:       value_pool[k] = WORD_MAX;
        2:       value_pool[k] = '0;
        3:       value_pool[k] = -1;
        default: value_pool[k] = $urandom();
      endcase
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 70) return value_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  // Pushes dominate so the stack spends most of its time partly filled;
  // search and update get a large share since they have the most paths.
  function automatic logic [MODE_W-1:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return MODE_PUSH;
    if (r < 45) return MODE_POP;
    if (r < 50) return MODE_PEEK;
    if (r < 53) return MODE_SIZE;
    if (r < 56) return MODE_IS_EMPTY;
    if (r < 68) return MODE_SEARCH;
    if (r < 80) return MODE_UPDATE;
    if (r < 85) return MODE_REVERSE;
    if (r < 87) return MODE_CLEAR;
    if (r < 95) return MODE_DISPLAY;
    return MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
  endfunction

  task automatic pick_pacing();
    case ($urandom_range(0, 3))
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 10; stall_pct = 10; end
      2: begin idle_pct = 30; stall_pct = 30; end
      default: begin idle_pct = 5; stall_pct = 50; end
    endcase
  endtask

  initial begin
    int base_ops;
    bit first_phase;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling. Every operation on an empty stack first.
    send_op(MODE_POP,      '0, '0);
    send_op(MODE_PEEK,     '0, '0);
    send_op(MODE_SEARCH,   WORD_MIN, '0);
    send_op(MODE_UPDATE,   WORD_MAX, 32'sd1);
    send_op(MODE_DISPLAY,  '0, '0);
    send_op(MODE_REVERSE,  '0, '0);
    send_op(MODE_IS_EMPTY, '0, '0);
    send_op(MODE_CLEAR,    '0, '0);
    send_op(MODE_SIZE,     '0, '0);

    // Extreme words; the stack then holds MIN, MAX, 0, -1 from the bottom.
    send_op(MODE_PUSH, WORD_MIN, '0);
    send_op(MODE_PUSH, WORD_MAX, '0);
    send_op(MODE_PUSH, '0, '0);
    send_op(MODE_PUSH, -1, '0);

    // A hit and a miss. Then make a duplicate MIN and update it, so only
    // the upper of the two copies may change.
    send_op(MODE_SEARCH, -1, '0);
    send_op(MODE_SEARCH, 32'sh1234_5678, '0);
    send_op(MODE_UPDATE, WORD_MAX, WORD_MIN);
    send_op(MODE_UPDATE, WORD_MIN, 32'sd5);
    send_op(MODE_UPDATE, 32'sd777, 32'sd1);

    send_op(MODE_DISPLAY,  '0, '0);
    send_op(MODE_REVERSE,  '0, '0);
    send_op(MODE_PEEK,     '0, '0);
    send_op(MODE_POP,      '0, '0);
    send_op(MODE_IS_EMPTY, '0, '0);
    send_op(MODE_SIZE,     '0, '0);
    send_op(MODE_UNUSED_LAST, WORD_MAX, WORD_MIN);

    // Let everything drain once before the random part begins.
    pause_until_drained();

    // Random part in phases. The first phase fills the stack past full so
    // that the overflow case is always reached.
    base_ops    = sent_ops;
    first_phase = 1'b1;
    while (sent_ops - base_ops < RANDOM_OPS) begin
      refresh_pool();
      pick_pacing();
      case (first_phase ? 0 : $urandom_range(0, 9))
        0, 1: begin
          repeat (STACK_DEPTH + $urandom_range(1, 2)) send_op(MODE_PUSH, pick_value(), $urandom());
          send_op(MODE_DISPLAY, '0, '0);
        end
        2: begin
          repeat ($urandom_range(4, STACK_DEPTH + 1)) send_op(MODE_POP, $urandom(), $urandom());
          send_op(MODE_DISPLAY, '0, '0);
        end
        default: begin
          repeat ($urandom_range(10, 30)) send_op(pick_mode(), pick_value(), pick_value());
        end
      endcase
      first_phase = 1'b0;
      if ($urandom_range(0, 7) == 0) pause_until_drained();
    end

    // Wait out every owed beat, then give a late or stray beat time to show.
    stall_pct = 0;
    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("** lifo_stack_with_search: PASSED **");
    end else begin
      $display("** lifo_stack_with_search: FAILED **");
    end
    $finish;
  end

endmodule
